[rtl/core/ctcc_pkg.sv]
// shared types, constants and the byte-wide crc-32 update for the chunk trailer checker
// no dependencies
package ctcc_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
  localparam logic [15:0] MIN_LEN   = 16'd10;
  localparam logic [15:0] LEN_RESET = 16'd64;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
  localparam logic [1:0] STATUS_TOTAL_ERR = 2'd2;

  localparam logic REG_CHUNK_LENGTH = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } ctcc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] trailer_index;
    logic [15:0] chunk_total;
  } ctcc_out_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/ctcc_tracker.sv]
// chunk position, crc accumulator, trailer captures and status decision
// depends on ctcc_pkg
module ctcc_tracker
  import ctcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  ctcc_in_t    item,
  input  logic [15:0] chunk_len,
  output logic        last,
  output ctcc_out_t   result
);

  logic [31:0] crc_r, crc_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] index_r, index_nxt;
  logic [15:0] total_r, total_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [15:0] latched_r, latched_nxt;
  logic        known_r, known_nxt;

  logic [15:0] len;
  logic [15:0] remain;
  logic        known_eff;

  assign len    = (chunk_len < MIN_LEN) ? MIN_LEN : chunk_len;
  assign last   = (count_r >= (len - 16'd1));
  assign remain = last ? 16'd0 : (len - 16'd1 - count_r);
  assign known_eff = known_r && !((count_r == 16'd0) && item.new_message);

  always_comb begin
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    index_nxt   = index_r;
    total_nxt   = total_r;
    stored_nxt  = stored_r;
    latched_nxt = latched_r;
    known_nxt   = known_eff;
    result.status        = STATUS_OK;
    result.trailer_index = index_r;
    result.chunk_total   = total_r;

    if (remain >= 16'd4) begin
      crc_nxt = crc_byte(crc_r, item.data_byte);
    end

    case (remain)
      16'd7: index_nxt[7:0]    = item.data_byte;
      16'd6: index_nxt[15:8]   = item.data_byte;
      16'd5: total_nxt[7:0]    = item.data_byte;
      16'd4: total_nxt[15:8]   = item.data_byte;
      16'd3: stored_nxt[7:0]   = item.data_byte;
      16'd2: stored_nxt[15:8]  = item.data_byte;
      16'd1: stored_nxt[23:16] = item.data_byte;
      16'd0: stored_nxt[31:24] = item.data_byte;
      default: ;
    endcase

    if (last) begin
      // crc is not advanced on the last byte, so crc_r is final here
      if (stored_nxt != ~crc_r) begin
        result.status = STATUS_CRC_ERR;
      end else if (!known_eff) begin
        latched_nxt = total_r;
        known_nxt   = 1'b1;
      end else if (total_r != latched_r) begin
        result.status = STATUS_TOTAL_ERR;
      end
      crc_nxt   = CRC_ONES;
      count_nxt = 16'd0;
    end else begin
      count_nxt = count_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_ONES;
      count_r   <= 16'd0;
      index_r   <= 16'd0;
      total_r   <= 16'd0;
      stored_r  <= 32'd0;
      latched_r <= 16'd0;
      known_r   <= 1'b0;
    end else if (step) begin
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
      index_r   <= index_nxt;
      total_r   <= total_nxt;
      stored_r  <= stored_nxt;
      latched_r <= latched_nxt;
      known_r   <= known_nxt;
    end
  end

endmodule

[rtl/core/chunk_trailer_crc_check.sv]
// top level of the chunk trailer checker: config register, input and result registers
// depends on ctcc_pkg and ctcc_tracker
//
// Takes one chunk byte per cycle and reports one result per chunk, on its last byte:
// status (0 accepted, 1 crc mismatch, 2 total mismatch) plus the index and total
// read from the 8-byte trailer. A byte passes an input register, then a byte-wide
// crc-32 update and trailer capture write the chunk state and, on the last byte,
// the result register, which loads when the last byte leaves the input register.
// Sustained rate is one byte per cycle. The input stalls only when a chunk-ending
// byte sits in the input register while the previous result is still held.
// chunk_length sits at byte address 0; the user must see that it is written only while
// the block is idle, since the block itself does not enforce this.
module chunk_trailer_crc_check
  import ctcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ctcc_in_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output ctcc_out_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] len_r;
  logic        s1_valid_r;
  ctcc_in_t    s1_item_r;
  logic        out_valid_r;
  ctcc_out_t   out_item_r;

  logic        last;
  ctcc_out_t   result;
  logic        s1_go;
  logic        in_take;
  logic        cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_CHUNK_LENGTH) && (cfg_paddr[1:0] == 2'd0);
  assign cfg_prdata = cfg_hit ? {16'd0, len_r} : 32'd0;

  // a chunk-ending byte needs the result register free
  assign s1_go    = s1_valid_r && !(last && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  ctcc_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .item      (s1_item_r),
    .chunk_len (len_r),
    .last      (last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
        len_r <= cfg_pwdata[15:0];
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_go && last) begin
      out_item_r <= result;
    end
  end

endmodule

[tb/chunk_trailer_crc_check_tb.sv]
// testbench for chunk_trailer_crc_check: byte stimulus, chunk status prediction and checking
// depends on ctcc_pkg and the chunk_trailer_crc_check rtl
`timescale 1ns / 100ps

module chunk_trailer_crc_check_tb
  import ctcc_pkg::*;
;

  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  class chunk_status_board;
    logic [15:0] chunk_len;
    logic [31:0] crc_run;
    int unsigned byte_count;
    logic [15:0] index_field;
    logic [15:0] total_field;
    logic [31:0] trailer_crc;
    logic [15:0] latched_total;
    bit          total_known;
    ctcc_out_t   expected_status[$];
    int unsigned errors;

    function new();
      chunk_len     = LEN_RESET;
      crc_run       = CRC_ONES;
      byte_count    = 0;
      index_field   = '0;
      total_field   = '0;
      trailer_crc   = '0;
      latched_total = '0;
      total_known   = 1'b0;
      errors        = 0;
    endfunction

    function void set_length(logic [15:0] v);
      chunk_len = v;
    endfunction

    // one accepted byte, pushes a status when it ends a chunk
    function void predict_status(ctcc_in_t it);
      int unsigned eff;
      int unsigned r;
      bit          last;
      logic [7:0]  b;
      ctcc_out_t   res;
      b    = it.data_byte;
      eff  = 32'((chunk_len < MIN_LEN) ? MIN_LEN : chunk_len);
      last = (byte_count + 1 >= eff);
      r    = last ? 0 : (eff - 1 - byte_count);
      if (byte_count == 0 && it.new_message) begin
        total_known = 1'b0;
      end
      if (r >= 4) begin
        crc_run = crc32_step(crc_run, b);
      end
      case (r)
        7: index_field[7:0]   = b;
        6: index_field[15:8]  = b;
        5: total_field[7:0]   = b;
        4: total_field[15:8]  = b;
        3: trailer_crc[7:0]   = b;
        2: trailer_crc[15:8]  = b;
        1: trailer_crc[23:16] = b;
        0: trailer_crc[31:24] = b;
        default: ;
      endcase
      if (!last) begin
        byte_count = byte_count + 1;
        return;
      end
      if (trailer_crc != (crc_run ^ CRC_ONES)) begin
        res.status = STATUS_CRC_ERR;
      end else if (!total_known) begin
        latched_total = total_field;
        total_known   = 1'b1;
        res.status    = STATUS_OK;
      end else if (total_field != latched_total) begin
        res.status = STATUS_TOTAL_ERR;
      end else begin
        res.status = STATUS_OK;
      end
      res.trailer_index = index_field;
      res.chunk_total   = total_field;
      expected_status.push_back(res);
      crc_run    = CRC_ONES;
      byte_count = 0;
    endfunction

    function void check_status(ctcc_out_t got);
      ctcc_out_t exp;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%t unexpected result: expected none actual %h", $time, got);
        return;
      end
      exp = expected_status.pop_front();
      if (got.status != exp.status) begin
        errors++;
        $display("%t status: expected %0d actual %0d", $time, exp.status, got.status);
      end
      if (got.trailer_index != exp.trailer_index) begin
        errors++;
        $display("%t trailer_index: expected %h actual %h", $time, exp.trailer_index,
                 got.trailer_index);
      end
      if (got.chunk_total != exp.chunk_total) begin
        errors++;
        $display("%t chunk_total: expected %h actual %h", $time, exp.chunk_total,
                 got.chunk_total);
      end
    endfunction
  endclass

  localparam int unsigned STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ctcc_in_t    in_item;
  logic        out_valid;
  logic        out_stall;
  ctcc_out_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  chunk_status_board sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  int unsigned gen_len;
  logic [15:0] msg_total;
  logic [15:0] index_ctr;

  chunk_trailer_crc_check dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check, random stall, activity tracking
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_status(out_item);
      end
      if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall))) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("[chunk_trailer_crc_check] ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic nm);
    ctcc_in_t it;
    it.data_byte   = b;
    it.new_message = nm;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.predict_status(it);
    bytes_sent++;
  endtask

  // wait for every expected status, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_CHUNK_LENGTH, 2'b00};
    cfg_pwdata  <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_length(v);
    gen_len = 32'((v < MIN_LEN) ? MIN_LEN : v);
  endtask

  // random bytes until the block sits at a chunk boundary
  task automatic realign();
    while (sb.byte_count != 0) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic send_chunk(input logic [15:0] idx, input logic [15:0] tot,
                            input logic nm, input bit corrupt);
    logic [7:0]  chunk_bytes[$];
    logic [31:0] c;
    int unsigned pos;
    for (int i = 0; i < gen_len - 8; i++) begin
      chunk_bytes.push_back(8'($urandom_range(255)));
    end
    chunk_bytes.push_back(idx[7:0]);
    chunk_bytes.push_back(idx[15:8]);
    chunk_bytes.push_back(tot[7:0]);
    chunk_bytes.push_back(tot[15:8]);
    c = CRC_ONES;
    foreach (chunk_bytes[i]) begin
      c = crc32_step(c, chunk_bytes[i]);
    end
    c = c ^ CRC_ONES;
    for (int i = 0; i < 4; i++) begin
      chunk_bytes.push_back(c[8*i +: 8]);
    end
    if (corrupt) begin
      pos = $urandom_range(gen_len - 1);
      chunk_bytes[pos] = chunk_bytes[pos] ^ (8'd1 << $urandom_range(7));
    end
    foreach (chunk_bytes[i]) begin
      // new_message on later bytes must be ignored
      send_byte(chunk_bytes[i], (i == 0) ? nm : ($urandom_range(9) == 0));
    end
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return 16'($urandom_range(10, 40));
    if (sel < 65) return MIN_LEN;
    if (sel < 75) return 16'(2 * $urandom_range(5, 30) + 1);
    if (sel < 85) return 16'($urandom_range(0, 9));
    return 16'($urandom_range(41, 200));
  endfunction

  task automatic run_segment();
    int unsigned seg_end;
    int unsigned sel;
    logic        nm;
    drain();
    write_length(pick_length());
    realign();
    seg_end = bytes_sent + $urandom_range(80, 200);
    while (bytes_sent < seg_end) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        // noise that breaks chunk alignment
        repeat ($urandom_range(1, gen_len)) begin
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        realign();
      end else begin
        nm = ($urandom_range(3) == 0);
        if (nm) begin
          msg_total = 16'($urandom_range(16'hFFFF));
        end
        index_ctr++;
        send_chunk(($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF)) : index_ctr,
                   ($urandom_range(9) < 7) ? msg_total : 16'($urandom_range(16'hFFFF)),
                   nm, ($urandom_range(99) < 15));
      end
    end
    // at random, leave a chunk part done so the next length write lands mid-chunk
    if ($urandom_range(1)) begin
      repeat ($urandom_range(1, gen_len - 1)) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 20;
    recv_idle_pct = 65;
    bytes_sent    = 0;
    gen_len       = 32'(LEN_RESET);
    msg_total     = '0;
    index_ctr     = '0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    out_stall   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first chunk latches the total, then a total mismatch, then a bad crc
    write_length(MIN_LEN);
    send_chunk(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_chunk(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_chunk(16'h00FF, 16'hFF00, 1'b0, 1'b1);

    while (bytes_sent < 700) run_segment();
    send_idle_pct = 65;
    recv_idle_pct = 20;
    while (bytes_sent < 1400) run_segment();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 2000) run_segment();

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[chunk_trailer_crc_check] OK");
    end else begin
      $display("[chunk_trailer_crc_check] ERROR");
    end
    $finish;
  end

endmodule
